[sv/c_subset_lexer_unit_assert.svh]
// Assertion macros for the C subset lexer unit.
`ifndef C_SUBSET_LEXER_UNIT_ASSERT_SVH
`define C_SUBSET_LEXER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define CSL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
else $error("Lexer check failed in the same cycle.");

`define CSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
else $error("Lexer check failed in the following cycle.");

`else

`define CSL_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define CSL_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[sv/csl_pkg.sv]
// Shared types, codes and helper functions of the C subset lexer.
package csl_pkg;

	localparam int OFFSET_WIDTH = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef logic [OFFSET_WIDTH-1:0] pos_t;

	localparam pos_t POS_MAX = '1;

	localparam logic [2:0] KIND_RESERVED = 3'd0;
	localparam logic [2:0] KIND_IDENT = 3'd1;
	localparam logic [2:0] KIND_NUMBER = 3'd2;
	localparam logic [2:0] KIND_END = 3'd3;
	localparam logic [2:0] KIND_ERROR = 3'd4;

	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_OPER = 2'd1;
	localparam logic [1:0] MODE_NUMBER = 2'd2;
	localparam logic [1:0] MODE_RETURN = 2'd3;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BANG = 8'h21;
	localparam logic [7:0] CH_LT = 8'h3C;
	localparam logic [7:0] CH_EQ = 8'h3D;
	localparam logic [7:0] CH_GT = 8'h3E;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_E = 8'h65;
	localparam logic [7:0] CH_R = 8'h72;

	localparam logic [2:0] KW_LEN = 3'd6;

	typedef struct packed {
		logic valid;
		logic [2:0] kind;
		logic [7:0] c1;
		logic [7:0] c2;
		pos_t start;
		logic [15:0] len;
	} tok_t;

	// One input byte's worth of work: keyword letters, then token A, then token B.
	typedef struct packed {
		logic [2:0] letters;
		pos_t letter_base;
		tok_t tok_a;
		logic [63:0] value;
		tok_t tok_b;
	} desc_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic [QCNT_W-1:0] count;
	} qstat_t;

	function automatic logic [7:0] kw_char(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0: ch = 8'h72;
			3'd1: ch = 8'h65;
			3'd2: ch = 8'h74;
			3'd3: ch = 8'h75;
			3'd4: ch = 8'h72;
			3'd5: ch = 8'h6E;
			default: ch = CH_NUL;
		endcase
		return ch;
	endfunction

	function automatic pos_t pos_sat_add(input pos_t p, input logic [2:0] n);
		logic [OFFSET_WIDTH:0] s;
		s = {1'b0, p} + {{(OFFSET_WIDTH - 2){1'b0}}, n};
		return s[OFFSET_WIDTH] ? POS_MAX : s[OFFSET_WIDTH-1:0];
	endfunction

	function automatic logic [15:0] to_field16(input pos_t p);
		logic [31:0] w;
		w = 32'(p);
		return w[15:0];
	endfunction

endpackage

[sv/csl_in_if.sv]
// Input channel of the lexer: one text byte per item.
interface csl_in_if;
	logic valid;
	logic ready;
	logic [7:0] char_code;

	modport source(output valid, output char_code, input ready);
	modport sink(input valid, input char_code, output ready);
endinterface

[sv/csl_out_if.sv]
// Output channel of the lexer: one token result per item.
interface csl_out_if;
	logic valid;
	logic ready;
	logic [2:0] token_kind;
	logic [7:0] first_char;
	logic [7:0] second_char;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic [63:0] number_value;
	logic last_in_burst;

	modport source(output valid, output token_kind, output first_char, output second_char,
		output token_start, output token_length, output number_value,
		output last_in_burst, input ready);
	modport sink(input valid, input token_kind, input first_char, input second_char,
		input token_start, input token_length, input number_value,
		input last_in_burst, output ready);
endinterface

[sv/csl_queue.sv]
// Short queue of work descriptors between the lexer front and back.
module csl_queue import csl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input desc_t wr_desc,
	input logic pop,
	output desc_t rd_desc,
	output qstat_t stat
);

	desc_t mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	assign rd_desc = mem_q[rd_ptr_q];
	assign stat.full = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign stat.count = count_q;

endmodule

[sv/csl_front.sv]
// Lexer front: accepts text bytes, tracks pending tokens and builds work descriptors.
module csl_front import csl_pkg::*; (
	input logic clk,
	input logic arst_n,
	csl_in_if.sink char_in,
	input logic q_full,
	output logic push,
	output desc_t desc
);

	pos_t pos_q;
	logic [1:0] mode_q;
	logic [2:0] prefix_q;
	logic [7:0] pend_char_q;
	logic [63:0] acc_q;
	pos_t start_q;
	logic discard_q;

	pos_t pos_d;
	logic [1:0] mode_d;
	logic [2:0] prefix_d;
	logic [7:0] pend_char_d;
	logic [63:0] acc_d;
	pos_t start_d;
	logic discard_d;

	logic [7:0] c;
	logic accept;
	logic absorbed;
	logic [67:0] acc_sum;
	logic [63:0] acc_step;

	function automatic logic is_digit(input logic [7:0] ch);
		return (ch >= 8'h30) && (ch <= 8'h39);
	endfunction

	function automatic logic is_lower(input logic [7:0] ch);
		return (ch >= 8'h61) && (ch <= 8'h7A);
	endfunction

	function automatic logic is_word(input logic [7:0] ch);
		return is_lower(ch) || ((ch >= 8'h41) && (ch <= 8'h5A)) || is_digit(ch)
			|| (ch == CH_UNDER);
	endfunction

	function automatic logic is_space(input logic [7:0] ch);
		return ((ch >= 8'h09) && (ch <= 8'h0D)) || (ch == CH_SPACE);
	endfunction

	function automatic logic is_punct(input logic [7:0] ch);
		return ((ch >= 8'h21) && (ch <= 8'h2F)) || ((ch >= 8'h3A) && (ch <= 8'h40))
			|| ((ch >= 8'h5B) && (ch <= 8'h60)) || ((ch >= 8'h7B) && (ch <= 8'h7E));
	endfunction

	assign c = char_in.char_code;
	assign char_in.ready = !q_full;
	assign accept = char_in.valid && !q_full;

	// Saturating acc * 10 + digit, built from two shifted copies.
	assign acc_sum = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {64'd0, c[3:0]};
	assign acc_step = (|acc_sum[67:64]) ? '1 : acc_sum[63:0];

	always_comb begin
		pos_d = pos_q;
		mode_d = mode_q;
		prefix_d = prefix_q;
		pend_char_d = pend_char_q;
		acc_d = acc_q;
		start_d = start_q;
		discard_d = discard_q;
		desc = '0;
		desc.letter_base = start_q;
		absorbed = 1'b0;

		if (discard_q) begin
			absorbed = 1'b1;
		end else begin
			unique case (mode_q)
				MODE_OPER: begin
					mode_d = MODE_NONE;
					desc.tok_a.valid = 1'b1;
					desc.tok_a.kind = KIND_RESERVED;
					desc.tok_a.c1 = pend_char_q;
					desc.tok_a.start = start_q;
					if (c == CH_EQ) begin
						desc.tok_a.c2 = CH_EQ;
						desc.tok_a.len = 16'd2;
						absorbed = 1'b1;
					end else begin
						desc.tok_a.len = 16'd1;
					end
				end
				MODE_NUMBER: begin
					if (is_digit(c)) begin
						acc_d = acc_step;
						absorbed = 1'b1;
					end else begin
						desc.tok_a.valid = 1'b1;
						desc.tok_a.kind = KIND_NUMBER;
						desc.tok_a.start = start_q;
						desc.tok_a.len = to_field16(pos_q - start_q);
						desc.value = acc_q;
						acc_d = '0;
						mode_d = MODE_NONE;
					end
				end
				MODE_RETURN: begin
					if ((prefix_q != 3'd0) && (prefix_q < KW_LEN) && (c == kw_char(prefix_q))) begin
						prefix_d = prefix_q + 3'd1;
						absorbed = 1'b1;
					end else begin
						mode_d = MODE_NONE;
						prefix_d = '0;
						if (prefix_q >= KW_LEN) begin
							if (is_word(c)) begin
								desc.letters = KW_LEN;
							end else begin
								desc.tok_a.valid = 1'b1;
								desc.tok_a.kind = KIND_RESERVED;
								desc.tok_a.c1 = CH_R;
								desc.tok_a.c2 = CH_E;
								desc.tok_a.start = start_q;
								desc.tok_a.len = 16'd6;
							end
						end else if (prefix_q == 3'd5) begin
							if (c == CH_E) begin
								// The second r of the prefix starts a new match.
								desc.letters = 3'd4;
								start_d = pos_sat_add(start_q, 3'd4);
								mode_d = MODE_RETURN;
								prefix_d = 3'd2;
								absorbed = 1'b1;
							end else begin
								desc.letters = 3'd5;
							end
						end else begin
							desc.letters = prefix_q;
						end
					end
				end
				MODE_NONE: begin
				end
			endcase

			if (!absorbed) begin
				if (c == CH_NUL) begin
					desc.tok_b.valid = 1'b1;
					desc.tok_b.kind = KIND_END;
					desc.tok_b.start = pos_q;
				end else if (is_space(c)) begin
				end else if ((c == CH_EQ) || (c == CH_BANG) || (c == CH_LT) || (c == CH_GT)) begin
					mode_d = MODE_OPER;
					pend_char_d = c;
					start_d = pos_q;
				end else if (is_digit(c)) begin
					mode_d = MODE_NUMBER;
					acc_d = {60'd0, c[3:0]};
					start_d = pos_q;
				end else if (c == CH_R) begin
					mode_d = MODE_RETURN;
					prefix_d = 3'd1;
					start_d = pos_q;
				end else if (is_lower(c)) begin
					desc.tok_b.valid = 1'b1;
					desc.tok_b.kind = KIND_IDENT;
					desc.tok_b.c1 = c;
					desc.tok_b.start = pos_q;
					desc.tok_b.len = 16'd1;
				end else if (is_punct(c)) begin
					desc.tok_b.valid = 1'b1;
					desc.tok_b.kind = KIND_RESERVED;
					desc.tok_b.c1 = c;
					desc.tok_b.start = pos_q;
					desc.tok_b.len = 16'd1;
				end else begin
					desc.tok_b.valid = 1'b1;
					desc.tok_b.kind = KIND_ERROR;
					desc.tok_b.start = pos_q;
					discard_d = 1'b1;
				end
			end
		end

		if (c == CH_NUL) begin
			pos_d = '0;
			mode_d = MODE_NONE;
			prefix_d = '0;
			pend_char_d = '0;
			acc_d = '0;
			start_d = '0;
			discard_d = 1'b0;
		end else if (!discard_q) begin
			pos_d = pos_sat_add(pos_q, 3'd1);
		end
	end

	assign push = accept && ((desc.letters != 3'd0) || desc.tok_a.valid || desc.tok_b.valid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			mode_q <= MODE_NONE;
			prefix_q <= '0;
			pend_char_q <= '0;
			acc_q <= '0;
			start_q <= '0;
			discard_q <= 1'b0;
		end else if (accept) begin
			pos_q <= pos_d;
			mode_q <= mode_d;
			prefix_q <= prefix_d;
			pend_char_q <= pend_char_d;
			acc_q <= acc_d;
			start_q <= start_d;
			discard_q <= discard_d;
		end
	end

endmodule

[sv/csl_back.sv]
// Lexer back: expands descriptors into token results, one per unstalled cycle.
module csl_back import csl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input desc_t head,
	input logic q_empty,
	output logic pop,
	csl_out_if.source token_out
);

	logic [2:0] idx_q;
	logic out_valid_q;
	logic [2:0] kind_q;
	logic [7:0] c1_q;
	logic [7:0] c2_q;
	logic [15:0] start_q;
	logic [15:0] len_q;
	logic [63:0] value_q;
	logic last_q;

	logic load;
	logic last;
	logic [3:0] total;
	logic [2:0] kind;
	logic [7:0] c1;
	logic [7:0] c2;
	pos_t start;
	logic [15:0] len;
	logic [63:0] value;

	assign load = !q_empty && (!out_valid_q || token_out.ready);
	assign total = 4'(head.letters) + 4'(head.tok_a.valid) + 4'(head.tok_b.valid);
	assign last = (({1'b0, idx_q} + 4'd1) == total);
	assign pop = load && last;

	always_comb begin
		value = '0;
		if (idx_q < head.letters) begin
			kind = KIND_IDENT;
			c1 = kw_char(idx_q);
			c2 = CH_NUL;
			start = pos_sat_add(head.letter_base, idx_q);
			len = 16'd1;
		end else if ((idx_q == head.letters) && head.tok_a.valid) begin
			kind = head.tok_a.kind;
			c1 = head.tok_a.c1;
			c2 = head.tok_a.c2;
			start = head.tok_a.start;
			len = head.tok_a.len;
			value = head.value;
		end else begin
			kind = head.tok_b.kind;
			c1 = head.tok_b.c1;
			c2 = head.tok_b.c2;
			start = head.tok_b.start;
			len = head.tok_b.len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= last ? 3'd0 : idx_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (token_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= kind;
			c1_q <= c1;
			c2_q <= c2;
			start_q <= to_field16(start);
			len_q <= len;
			value_q <= value;
			last_q <= last;
		end
	end

	assign token_out.valid = out_valid_q;
	assign token_out.token_kind = kind_q;
	assign token_out.first_char = c1_q;
	assign token_out.second_char = c2_q;
	assign token_out.token_start = start_q;
	assign token_out.token_length = len_q;
	assign token_out.number_value = value_q;
	assign token_out.last_in_burst = last_q;

endmodule

[sv/c_subset_lexer_unit.sv]
// Top level of the C subset lexer: front, descriptor queue and back.
//
//   Channel     Direction  Item
//   char_in     in         one text byte, char_code 0 ends the text
//   token_out   out        one token result, last_in_burst on the last per byte
//
// The front takes one byte per cycle as long as the four-entry descriptor queue
// has room. The back delivers one result per cycle while token_out is ready,
// and a byte yields up to seven results. A result passes through the descriptor
// queue and the output register. Reset clears the lexer state, the queue
// pointers and count, and the output valid flag at once. A stall on token_out
// fills the queue and then drops char_in.ready.
`include "c_subset_lexer_unit_assert.svh"

module c_subset_lexer_unit import csl_pkg::*; (
	input logic clk,
	input logic arst_n,
	csl_in_if.sink char_in,
	csl_out_if.source token_out
);

	desc_t wr_desc;
	desc_t rd_desc;
	logic push;
	logic pop;
	qstat_t qs;

	csl_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.char_in(char_in),
		.q_full(qs.full),
		.push(push),
		.desc(wr_desc)
	);

	csl_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_desc(wr_desc),
		.pop(pop),
		.rd_desc(rd_desc),
		.stat(qs)
	);

	csl_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(rd_desc),
		.q_empty(qs.empty),
		.pop(pop),
		.token_out(token_out)
	);

	`CSL_ASSERT_IMPL(a_push_has_room, clk, arst_n, push, !qs.full)
	`CSL_ASSERT_IMPL(a_pop_has_item, clk, arst_n, pop, !qs.empty)
	`CSL_ASSERT_NEXT(a_count_up, clk, arst_n, push && !pop, qs.count == $past(qs.count) + QCNT_W'(1))
	`CSL_ASSERT_NEXT(a_count_down, clk, arst_n, pop && !push, qs.count == $past(qs.count) - QCNT_W'(1))

endmodule

[verif/tb_top.sv]
// Self-checking testbench of c_subset_lexer_unit: directed table and random texts.
`timescale 1ns / 1ps

module tb_top import csl_pkg::*;;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] first;
		logic [7:0] second;
		logic [15:0] start;
		logic [15:0] len;
		logic [63:0] value;
		logic last;
	} token_t;

	typedef enum logic [1:0] {ROW_PREDICTED, ROW_SILENT, ROW_TYPED} row_check_e;

	typedef struct packed {
		logic [7:0] ch;
		row_check_e check;
		token_t token;
	} dir_row_t;

	localparam int QUIET_LIMIT = 1000;
	localparam int TAIL_CYCLES = 40;
	localparam int RANDOM_ITEMS = 240;
	localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

	localparam token_t NO_TOKEN = '0;
	localparam token_t END_AT_START = '{kind: KIND_END, first: 8'h00, second: 8'h00,
		start: 16'd0, len: 16'd0, value: 64'd0, last: 1'b1};
	localparam token_t ERROR_AT_START = '{kind: KIND_ERROR, first: 8'h00, second: 8'h00,
		start: 16'd0, len: 16'd0, value: 64'd0, last: 1'b1};
	localparam token_t ERROR_AT_THREE = '{kind: KIND_ERROR, first: 8'h00, second: 8'h00,
		start: 16'd3, len: 16'd0, value: 64'd0, last: 1'b1};

	dir_row_t directed_rows [0:26] = '{
		'{CH_NUL, ROW_TYPED, END_AT_START},
		'{CH_LT, ROW_PREDICTED, NO_TOKEN},
		'{CH_EQ, ROW_PREDICTED, NO_TOKEN},
		'{8'h39, ROW_PREDICTED, NO_TOKEN},
		'{CH_R, ROW_PREDICTED, NO_TOKEN},
		'{CH_E, ROW_PREDICTED, NO_TOKEN},
		'{8'h74, ROW_PREDICTED, NO_TOKEN},
		'{8'h75, ROW_PREDICTED, NO_TOKEN},
		'{CH_R, ROW_PREDICTED, NO_TOKEN},
		'{CH_E, ROW_PREDICTED, NO_TOKEN},
		'{8'h74, ROW_PREDICTED, NO_TOKEN},
		'{8'h75, ROW_PREDICTED, NO_TOKEN},
		'{CH_R, ROW_PREDICTED, NO_TOKEN},
		'{8'h6E, ROW_PREDICTED, NO_TOKEN},
		'{CH_UNDER, ROW_PREDICTED, NO_TOKEN},
		'{CH_NUL, ROW_PREDICTED, NO_TOKEN},
		'{8'hFF, ROW_TYPED, ERROR_AT_START},
		'{8'h61, ROW_SILENT, NO_TOKEN},
		'{CH_NUL, ROW_SILENT, NO_TOKEN},
		'{CH_SPACE, ROW_PREDICTED, NO_TOKEN},
		'{CH_GT, ROW_PREDICTED, NO_TOKEN},
		'{CH_EQ, ROW_PREDICTED, NO_TOKEN},
		'{8'h7F, ROW_TYPED, ERROR_AT_THREE},
		'{CH_NUL, ROW_SILENT, NO_TOKEN},
		'{CH_BANG, ROW_PREDICTED, NO_TOKEN},
		'{8'h7A, ROW_PREDICTED, NO_TOKEN},
		'{CH_NUL, ROW_PREDICTED, NO_TOKEN}
	};

	logic clk;
	logic arst_n;

	csl_in_if char_bus();
	csl_out_if token_bus();

	c_subset_lexer_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.char_in(char_bus),
		.token_out(token_bus)
	);

	string keyword_text = "return";
	string u64_max_text = "18446744073709551615";

	pos_t text_pos = '0;
	logic [1:0] hold_mode = MODE_NONE;
	logic [2:0] kw_matched = '0;
	logic [7:0] held_op = '0;
	logic [63:0] num_acc = '0;
	pos_t tok_pos = '0;
	bit skipping = 1'b0;

	token_t burst[$];
	token_t due_tokens[$];
	logic [7:0] text_bytes[$];
	int mismatch_count = 0;
	int quiet_cycles = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic pos_t sat_add(input pos_t a, input int unsigned b);
		int unsigned s;
		s = a + b;
		return (s > POS_MAX) ? POS_MAX : pos_t'(s);
	endfunction

	function automatic bit is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic bit is_lower(input logic [7:0] c);
		return c >= 8'h61 && c <= 8'h7A;
	endfunction

	function automatic bit is_upper(input logic [7:0] c);
		return c >= 8'h41 && c <= 8'h5A;
	endfunction

	function void clear_lexer();
		text_pos = '0;
		hold_mode = MODE_NONE;
		kw_matched = '0;
		held_op = '0;
		num_acc = '0;
		tok_pos = '0;
		skipping = 1'b0;
	endfunction

	function void push_token(input logic [2:0] kind, input logic [7:0] first,
		input logic [7:0] second, input pos_t start, input logic [15:0] len,
		input logic [63:0] value);
		if (burst.size() < 7)
			burst.push_back('{kind, first, second, start, len, value, 1'b0});
	endfunction

	function void spell_prefix(input int n);
		for (int i = 0; i < n && i < 6; i++)
			push_token(KIND_IDENT, keyword_text[i], 8'h00, sat_add(tok_pos, i), 16'd1, 64'd0);
	endfunction

	function automatic bit settle_pending(input logic [7:0] c);
		int k;
		logic [63:0] d;
		if (hold_mode == MODE_OPER) begin
			hold_mode = MODE_NONE;
			if (c == CH_EQ) begin
				push_token(KIND_RESERVED, held_op, CH_EQ, tok_pos, 16'd2, 64'd0);
				return 1'b1;
			end
			push_token(KIND_RESERVED, held_op, 8'h00, tok_pos, 16'd1, 64'd0);
			return 1'b0;
		end
		if (hold_mode == MODE_NUMBER) begin
			if (is_digit(c)) begin
				d = 64'(c - 8'h30);
				if (num_acc > (U64_MAX - d) / 10)
					num_acc = U64_MAX;
				else
					num_acc = num_acc * 10 + d;
				return 1'b1;
			end
			push_token(KIND_NUMBER, 8'h00, 8'h00, tok_pos, 16'(text_pos - tok_pos), num_acc);
			num_acc = '0;
			hold_mode = MODE_NONE;
			return 1'b0;
		end
		if (hold_mode == MODE_RETURN) begin
			k = kw_matched;
			if (k >= 1 && k < 6 && c == keyword_text[k]) begin
				kw_matched = 3'(k + 1);
				return 1'b1;
			end
			hold_mode = MODE_NONE;
			if (k >= 6) begin
				if (is_lower(c) || is_upper(c) || is_digit(c) || c == CH_UNDER)
					spell_prefix(6);
				else
					push_token(KIND_RESERVED, CH_R, CH_E, tok_pos, 16'd6, 64'd0);
			end else if (k == 5) begin
				spell_prefix(4);
				tok_pos = sat_add(tok_pos, 4);
				if (c == CH_E) begin
					hold_mode = MODE_RETURN;
					kw_matched = 3'd2;
					return 1'b1;
				end
				push_token(KIND_IDENT, CH_R, 8'h00, tok_pos, 16'd1, 64'd0);
			end else begin
				spell_prefix(k);
			end
			kw_matched = '0;
			return 1'b0;
		end
		hold_mode = MODE_NONE;
		return 1'b0;
	endfunction

	function void start_token(input logic [7:0] c);
		if (c == CH_NUL) begin
			push_token(KIND_END, 8'h00, 8'h00, text_pos, 16'd0, 64'd0);
		end else if ((c >= 8'd9 && c <= 8'd13) || c == CH_SPACE) begin
		end else if (c == CH_EQ || c == CH_BANG || c == CH_LT || c == CH_GT) begin
			hold_mode = MODE_OPER;
			held_op = c;
			tok_pos = text_pos;
		end else if (is_digit(c)) begin
			hold_mode = MODE_NUMBER;
			num_acc = 64'(c - 8'h30);
			tok_pos = text_pos;
		end else if (c == CH_R) begin
			hold_mode = MODE_RETURN;
			kw_matched = 3'd1;
			tok_pos = text_pos;
		end else if (is_lower(c)) begin
			push_token(KIND_IDENT, c, 8'h00, text_pos, 16'd1, 64'd0);
		end else if ((c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
			(c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E)) begin
			push_token(KIND_RESERVED, c, 8'h00, text_pos, 16'd1, 64'd0);
		end else begin
			push_token(KIND_ERROR, 8'h00, 8'h00, text_pos, 16'd0, 64'd0);
			skipping = 1'b1;
		end
	endfunction

	function void lex_byte(input logic [7:0] c);
		token_t tail;
		burst.delete();
		if (skipping) begin
			if (c == CH_NUL)
				clear_lexer();
			return;
		end
		if (!settle_pending(c))
			start_token(c);
		if (c == CH_NUL)
			clear_lexer();
		else
			text_pos = sat_add(text_pos, 1);
		if (burst.size() > 0) begin
			tail = burst.pop_back();
			tail.last = 1'b1;
			burst.push_back(tail);
		end
	endfunction

	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task feed_char(input logic [7:0] c, input row_check_e check, input token_t typed,
		input int gap);
		@(negedge clk);
		if (gap > 0) begin
			char_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		char_bus.valid <= 1'b1;
		char_bus.char_code <= c;
		do @(posedge clk); while (!char_bus.ready);
		lex_byte(c);
		if (check == ROW_PREDICTED) begin
			foreach (burst[i])
				due_tokens.push_back(burst[i]);
		end else if (check == ROW_TYPED) begin
			due_tokens.push_back(typed);
		end
	endtask

	task drain_tokens();
		@(negedge clk);
		char_bus.valid <= 1'b0;
		while (due_tokens.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task compose_text();
		int frags;
		int pick;
		int spoil_at;
		int n;
		logic [7:0] b;
		text_bytes.delete();
		frags = $urandom_range(2, 12);
		spoil_at = ($urandom_range(0, 99) < 12) ? $urandom_range(0, frags - 1) : -1;
		for (int f = 0; f < frags; f++) begin
			if (f == spoil_at) begin
				case ($urandom_range(0, 3))
					0: b = 8'($urandom_range(1, 8));
					1: b = 8'($urandom_range(14, 31));
					2: b = 8'($urandom_range(8'h41, 8'h5A));
					default: b = 8'($urandom_range(8'h7F, 8'hFF));
				endcase
				text_bytes.push_back(b);
				repeat ($urandom_range(0, 5)) text_bytes.push_back(8'($urandom_range(1, 255)));
			end
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				for (int i = 0; i < 6; i++)
					text_bytes.push_back(keyword_text[i]);
				if ($urandom_range(0, 2) == 0) begin
					case ($urandom_range(0, 3))
						0: b = 8'($urandom_range(8'h61, 8'h7A));
						1: b = 8'($urandom_range(8'h41, 8'h5A));
						2: b = 8'($urandom_range(8'h30, 8'h39));
						default: b = CH_UNDER;
					endcase
					text_bytes.push_back(b);
				end
			end else if (pick < 22) begin
				n = $urandom_range(1, 5);
				for (int i = 0; i < n; i++)
					text_bytes.push_back(keyword_text[i]);
				if (n == 5 && $urandom_range(0, 1) == 1) begin
					for (int i = 1; i < 6; i++)
						text_bytes.push_back(keyword_text[i]);
				end
			end else if (pick < 37) begin
				if ($urandom_range(0, 9) == 0) begin
					if ($urandom_range(0, 1) == 1) begin
						for (int i = 0; i < 19; i++)
							text_bytes.push_back(u64_max_text[i]);
						text_bytes.push_back(8'(8'h30 + $urandom_range(4, 9)));
					end else begin
						repeat ($urandom_range(18, 22))
							text_bytes.push_back(8'(8'h30 + $urandom_range(0, 9)));
					end
				end else begin
					repeat ($urandom_range(1, 3))
						text_bytes.push_back(8'(8'h30 + $urandom_range(0, 9)));
				end
			end else if (pick < 50) begin
				case ($urandom_range(0, 3))
					0: b = CH_EQ;
					1: b = CH_BANG;
					2: b = CH_LT;
					default: b = CH_GT;
				endcase
				text_bytes.push_back(b);
				if ($urandom_range(0, 1) == 1)
					text_bytes.push_back(CH_EQ);
			end else if (pick < 65) begin
				text_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
			end else if (pick < 78) begin
				do b = 8'($urandom_range(8'h21, 8'h7E));
				while (is_digit(b) || is_lower(b) || is_upper(b));
				text_bytes.push_back(b);
			end else begin
				n = $urandom_range(0, 5);
				text_bytes.push_back((n == 5) ? CH_SPACE : 8'(9 + n));
			end
		end
		text_bytes.push_back(CH_NUL);
	endtask

	function void check_field(input string field, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin
		token_t want;
		if (arst_n && token_bus.valid && token_bus.ready) begin
			if (due_tokens.size() == 0) begin
				$error("token_kind %0d at offset %0d arrived with nothing expected",
					token_bus.token_kind, token_bus.token_start);
				mismatch_count++;
			end else begin
				want = due_tokens.pop_front();
				check_field("token_kind", want.kind, token_bus.token_kind);
				check_field("first_char", want.first, token_bus.first_char);
				check_field("second_char", want.second, token_bus.second_char);
				check_field("token_start", want.start, token_bus.token_start);
				check_field("token_length", want.len, token_bus.token_length);
				check_field("number_value", want.value, token_bus.number_value);
				check_field("last_in_burst", want.last, token_bus.last_in_burst);
			end
		end
	end

	always @(posedge clk) begin
		if ((char_bus.valid && char_bus.ready) || (token_bus.valid && token_bus.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int run_len;
		int hold_len;
		int r;
		token_bus.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			r = $urandom_range(0, 99);
			run_len = (r < 15) ? $urandom_range(30, 80) : $urandom_range(1, 8);
			r = $urandom_range(0, 99);
			if (r < 40)
				hold_len = 0;
			else if (r < 90)
				hold_len = $urandom_range(1, 3);
			else
				hold_len = $urandom_range(12, 40);
			repeat (run_len) begin
				@(negedge clk);
				token_bus.ready <= 1'b1;
			end
			repeat (hold_len) begin
				@(negedge clk);
				token_bus.ready <= 1'b0;
			end
		end
	end

	initial begin
		int counted;
		bit steady;
		arst_n = 1'b0;
		char_bus.valid = 1'b0;
		char_bus.char_code = 8'h00;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[r])
			feed_char(directed_rows[r].ch, directed_rows[r].check, directed_rows[r].token,
				pick_gap());
		drain_tokens();

		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			compose_text();
			steady = ($urandom_range(0, 4) == 0);
			foreach (text_bytes[i]) begin
				if (!skipping)
					counted++;
				feed_char(text_bytes[i], ROW_PREDICTED, NO_TOKEN, steady ? 0 : pick_gap());
			end
			if ($urandom_range(0, 9) == 0)
				drain_tokens();
		end
		drain_tokens();

		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
